// ===== sv/seven_segment_rect_generator_core_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef SEVEN_SEGMENT_RECT_GENERATOR_CORE_MACROS_SVH
`define SEVEN_SEGMENT_RECT_GENERATOR_CORE_MACROS_SVH

// consequent checked in the cycle after the antecedent
`define SSRG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// consequent checked in the same cycle as the antecedent
`define SSRG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/ssrg_pkg.sv =====
// types, constants and the digit pattern table of the rectangle generator
// no dependencies
package ssrg_pkg;

  localparam int unsigned ThickW = 8;
  localparam logic [ThickW-1:0] ThickReset = 8'd10;
  localparam logic [7:0] DigitMax = 8'd9;

  // segment bits
  localparam int unsigned SEG_TOP = 0;
  localparam int unsigned SEG_UR  = 1;
  localparam int unsigned SEG_LR  = 2;
  localparam int unsigned SEG_BOT = 3;
  localparam int unsigned SEG_LL  = 4;
  localparam int unsigned SEG_UL  = 5;
  localparam int unsigned SEG_MID = 6;

  // rectangle slots in emission order
  localparam int unsigned NumRects = 8;
  localparam logic [2:0] RECT_BG = 3'd0;
  localparam logic [2:0] RECT_A  = 3'd1;
  localparam logic [2:0] RECT_D  = 3'd2;
  localparam logic [2:0] RECT_G  = 3'd3;
  localparam logic [2:0] RECT_F  = 3'd4;
  localparam logic [2:0] RECT_E  = 3'd5;
  localparam logic [2:0] RECT_B  = 3'd6;
  localparam logic [2:0] RECT_C  = 3'd7;

  typedef struct packed {
    logic [15:0] origin_x;
    logic [15:0] origin_y;
    logic [15:0] box_width;
    logic [15:0] box_height;
    logic [7:0]  digit_value;
    logic [15:0] fg_color;
    logic [15:0] back_color;
  } req_t;

  typedef struct packed {
    logic [15:0] rect_x;
    logic [15:0] rect_y;
    logic [15:0] rect_width;
    logic [15:0] rect_height;
    logic [15:0] rect_color;
    logic        last_rect;
  } rect_t;

  typedef struct packed {
    logic load;
    logic calc;
    logic mask;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic mask_empty;
    logic mask_last;
  } sts_t;

  function automatic logic [6:0] seg_pattern(input logic [7:0] digit);
    logic [6:0] pat;
    pat = '0;
    case (digit)
      8'd0: pat = 7'b0111111;
      8'd1: pat = 7'b0000110;
      8'd2: pat = 7'b1011011;
      8'd3: pat = 7'b1001111;
      8'd4: pat = 7'b1100110;
      8'd5: pat = 7'b1101101;
      8'd6: pat = 7'b1111101;
      8'd7: pat = 7'b0000111;
      8'd8: pat = 7'b1111111;
      8'd9: pat = 7'b1101111;
      default: pat = '0;
    endcase
    return pat;
  endfunction

endpackage

// ===== sv/ssrg_datapath.sv =====
// datapath: thickness register, request register, geometry, rectangle mask, output payload
// depends on ssrg_pkg
module ssrg_datapath import ssrg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ThickW-1:0] cfg_wdata_i,
  input  req_t              in_item_i,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  output rect_t             rect_o
);

  logic [ThickW-1:0] thick_q;
  req_t              req_q;
  logic [15:0]       t16;
  logic [8:0]        t2;
  logic [9:0]        t3;

  logic [15:0] lo_q, up_q, bar_w_q, bar_x_q, top_y_q, low_y_q, mid_y_q, up_y_q, right_x_q;
  logic        bars_ok_q;
  logic [15:0] lo_d, up_d, bar_w_d, bar_x_d, top_y_d, low_y_d, mid_y_d, up_y_d, right_x_d;
  logic        bars_ok_d;
  logic [16:0] vs17;
  logic [15:0] vs;

  logic [NumRects-1:0] mask_q, mask_d, mask_new, mask_rest;
  logic [6:0]          pat;
  logic                digit_ok, t_nz;
  logic [2:0]          sel;
  rect_t               rect_q, rect_d;

  assign t16 = {8'd0, thick_q};
  assign t2  = {thick_q, 1'b0};
  assign t3  = {1'b0, t2} + {2'd0, thick_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thick_q <= ThickReset;
    end else if (cfg_we_i) begin
      thick_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= in_item_i;
    end
  end

  // geometry
  always_comb begin
    vs17      = {1'b0, req_q.box_height} - {7'd0, t3};
    vs        = vs17[16] ? 16'd0 : vs17[15:0];
    lo_d      = {1'b0, vs[15:1]};
    up_d      = vs - lo_d;
    bars_ok_d = (req_q.box_width >= {7'd0, t2});
    bar_w_d   = req_q.box_width - {7'd0, t2};
    bar_x_d   = req_q.origin_x + t16;
    top_y_d   = req_q.origin_y + req_q.box_height - t16;
    low_y_d   = req_q.origin_y + t16;
    mid_y_d   = req_q.origin_y + lo_d + t16;
    up_y_d    = req_q.origin_y + lo_d + {7'd0, t2};
    right_x_d = req_q.origin_x + req_q.box_width - t16;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      lo_q      <= lo_d;
      up_q      <= up_d;
      bars_ok_q <= bars_ok_d;
      bar_w_q   <= bar_w_d;
      bar_x_q   <= bar_x_d;
      top_y_q   <= top_y_d;
      low_y_q   <= low_y_d;
      mid_y_q   <= mid_y_d;
      up_y_q    <= up_y_d;
      right_x_q <= right_x_d;
    end
  end

  // which rectangles appear
  always_comb begin
    pat       = seg_pattern(req_q.digit_value);
    digit_ok  = (req_q.digit_value <= DigitMax);
    t_nz      = (thick_q != '0);
    mask_new  = '0;
    mask_new[RECT_BG] = digit_ok && (req_q.box_width != '0) && (req_q.box_height != '0);
    mask_new[RECT_A]  = pat[SEG_TOP] && bars_ok_q && (bar_w_q != '0) && t_nz;
    mask_new[RECT_D]  = pat[SEG_BOT] && bars_ok_q && (bar_w_q != '0) && t_nz;
    mask_new[RECT_G]  = pat[SEG_MID] && bars_ok_q && (bar_w_q != '0) && t_nz;
    mask_new[RECT_F]  = pat[SEG_UL] && t_nz && (up_q != '0);
    mask_new[RECT_E]  = pat[SEG_LL] && t_nz && (lo_q != '0);
    mask_new[RECT_B]  = pat[SEG_UR] && t_nz && (up_q != '0);
    mask_new[RECT_C]  = pat[SEG_LR] && t_nz && (lo_q != '0);
  end

  assign mask_rest = mask_q & (mask_q - 1'b1);

  always_comb begin
    mask_d = mask_q;
    if (cmd_i.mask) begin
      mask_d = mask_new;
    end else if (cmd_i.emit) begin
      mask_d = mask_rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_comb begin
    sel = '0;
    for (int i = NumRects - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        sel = 3'(i);
      end
    end
  end

  always_comb begin
    rect_d = '0;
    rect_d.rect_color = req_q.fg_color;
    rect_d.last_rect  = (mask_rest == '0);
    case (sel)
      RECT_BG: begin
        rect_d.rect_x      = req_q.origin_x;
        rect_d.rect_y      = req_q.origin_y;
        rect_d.rect_width  = req_q.box_width;
        rect_d.rect_height = req_q.box_height;
        rect_d.rect_color  = req_q.back_color;
      end
      RECT_A: begin
        rect_d.rect_x      = bar_x_q;
        rect_d.rect_y      = top_y_q;
        rect_d.rect_width  = bar_w_q;
        rect_d.rect_height = t16;
      end
      RECT_D: begin
        rect_d.rect_x      = bar_x_q;
        rect_d.rect_y      = req_q.origin_y;
        rect_d.rect_width  = bar_w_q;
        rect_d.rect_height = t16;
      end
      RECT_G: begin
        rect_d.rect_x      = bar_x_q;
        rect_d.rect_y      = mid_y_q;
        rect_d.rect_width  = bar_w_q;
        rect_d.rect_height = t16;
      end
      RECT_F: begin
        rect_d.rect_x      = req_q.origin_x;
        rect_d.rect_y      = up_y_q;
        rect_d.rect_width  = t16;
        rect_d.rect_height = up_q;
      end
      RECT_E: begin
        rect_d.rect_x      = req_q.origin_x;
        rect_d.rect_y      = low_y_q;
        rect_d.rect_width  = t16;
        rect_d.rect_height = lo_q;
      end
      RECT_B: begin
        rect_d.rect_x      = right_x_q;
        rect_d.rect_y      = up_y_q;
        rect_d.rect_width  = t16;
        rect_d.rect_height = up_q;
      end
      RECT_C: begin
        rect_d.rect_x      = right_x_q;
        rect_d.rect_y      = low_y_q;
        rect_d.rect_width  = t16;
        rect_d.rect_height = lo_q;
      end
      default: rect_d.rect_x = req_q.origin_x;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      rect_q <= rect_d;
    end
  end

  assign rect_o           = rect_q;
  assign sts_o.mask_empty = (mask_q == '0);
  assign sts_o.mask_last  = (mask_rest == '0);

endmodule

// ===== sv/ssrg_ctrl.sv =====
// controller: request sequencing and output valid register
// depends on ssrg_pkg
module ssrg_ctrl import ssrg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_MASK = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d  = state_q;
    cmd_o    = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = ST_MASK;
      end
      ST_MASK: begin
        cmd_o.mask = 1'b1;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.mask_empty) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.mask_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/seven_segment_rect_generator_core.sv =====
// top level of the seven-segment rectangle generator: controller plus datapath
// depends on ssrg_pkg, ssrg_ctrl, ssrg_datapath
//
//   port group   direction  payload     handshake
//   in_*         in         req_t       in_valid_i / in_stall_o
//   out_*        out        rect_t      out_valid_o / out_stall_i
//   cfg_*        in         thickness   cfg_we_i, no wait
//
// an item yields n rectangles (at most 8), none when nothing is drawn, in these steps:
// load, geometry and mask steps, then one rectangle per cycle from the output register while the output is not stalled
// one item is worked at a time; in_stall_o is high from acceptance until the last rectangle
// is loaded, and output stalls hold the sequencer
// reset sets the thickness to 10 and empties the output register
module seven_segment_rect_generator_core import ssrg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ThickW-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  req_t              in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rect_t             out_item_o
);

  cmd_t cmd;
  sts_t sts;

  ssrg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ssrg_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rect_o      (out_item_o)
  );

endmodule

// ===== sv/ssrg_checker.sv =====
// port-level checks of the rectangle generator, bound to the top level
// depends on ssrg_pkg and the assertion macro header
`include "seven_segment_rect_generator_core_macros.svh"

module ssrg_checker import ssrg_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input rect_t             out_item_o
);

  `SSRG_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  `SSRG_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_item_o))

  `SSRG_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  `SSRG_ASSERT_SAME(a_idle_last, clk_i, rst_ni, out_valid_o && !in_stall_o, out_item_o.last_rect)

  `SSRG_ASSERT_SAME(a_nonzero, clk_i, rst_ni, out_valid_o,
    (out_item_o.rect_width != 16'd0) && (out_item_o.rect_height != 16'd0))

endmodule

bind seven_segment_rect_generator_core ssrg_checker u_ssrg_checker (.*);

// ===== tb/seven_segment_rect_generator_core_tb.sv =====
// testbench for seven_segment_rect_generator_core: digit requests in, filled rectangles out
// checks every rectangle against an in-bench predictor across several segment thicknesses
// depends on ssrg_pkg and the seven_segment_rect_generator_core rtl
module seven_segment_rect_generator_core_tb import ssrg_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [6:0] M_TOP = 7'(1 << SEG_TOP);
  localparam logic [6:0] M_UR  = 7'(1 << SEG_UR);
  localparam logic [6:0] M_LR  = 7'(1 << SEG_LR);
  localparam logic [6:0] M_BOT = 7'(1 << SEG_BOT);
  localparam logic [6:0] M_LL  = 7'(1 << SEG_LL);
  localparam logic [6:0] M_UL  = 7'(1 << SEG_UL);
  localparam logic [6:0] M_MID = 7'(1 << SEG_MID);
  localparam int DrainLimit = 20000;
  localparam int SettleCycles = 16;
  localparam int RandPerPhase = 50;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [ThickW-1:0] cfg_wdata_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  req_t              in_item_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  rect_t             out_item_o;

  req_t              req_queue[$];
  rect_t             pending_rects[$];
  logic [ThickW-1:0] thick_now = ThickReset;
  req_t              next_req;
  rect_t             want;
  int                error_count = 0;
  int                gap_left = 0;
  int                stall_left = 0;
  int                in_idle_pct = 20;
  int                out_stall_pct = 20;
  int                cycle_count = 0;
  bit                quiet = 1'b0;

  seven_segment_rect_generator_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string what, int unsigned got, int unsigned exp_val);
    error_count++;
    if (error_count <= 50) begin
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, exp_val);
    end
  endtask

  function automatic logic [6:0] lit_segments(logic [7:0] digit);
    logic [6:0] segs;
    segs = '0;
    case (digit)
      8'd0: segs = M_TOP | M_UR | M_LR | M_BOT | M_LL | M_UL;
      8'd1: segs = M_UR | M_LR;
      8'd2: segs = M_TOP | M_UR | M_BOT | M_LL | M_MID;
      8'd3: segs = M_TOP | M_UR | M_LR | M_BOT | M_MID;
      8'd4: segs = M_UR | M_LR | M_UL | M_MID;
      8'd5: segs = M_TOP | M_LR | M_BOT | M_UL | M_MID;
      8'd6: segs = M_TOP | M_LR | M_BOT | M_LL | M_UL | M_MID;
      8'd7: segs = M_TOP | M_UR | M_LR;
      8'd8: segs = M_TOP | M_UR | M_LR | M_BOT | M_LL | M_UL | M_MID;
      8'd9: segs = M_TOP | M_UR | M_LR | M_BOT | M_UL | M_MID;
      default: segs = '0;
    endcase
    return segs;
  endfunction

  function automatic void add_rect(int unsigned x, int unsigned y, int unsigned w,
                                   int unsigned h, int unsigned color);
    rect_t rc;
    rc.rect_x      = x[15:0];
    rc.rect_y      = y[15:0];
    rc.rect_width  = w[15:0];
    rc.rect_height = h[15:0];
    rc.rect_color  = color[15:0];
    rc.last_rect   = 1'b0;
    if (rc.rect_width != 0 && rc.rect_height != 0) begin
      pending_rects.push_back(rc);
    end
  endfunction

  function automatic void predict_rects(req_t r);
    int unsigned x, y, w, h, t, fg, vs, lo, up, bar_w, mid_y, up_y, right_x;
    int          first;
    logic [6:0]  segs;
    bit          bars_ok;
    x = r.origin_x;
    y = r.origin_y;
    w = r.box_width;
    h = r.box_height;
    t = thick_now;
    fg = r.fg_color;
    first = pending_rects.size();
    if (r.digit_value > DigitMax) begin
      return;
    end
    segs = lit_segments(r.digit_value);
    add_rect(x, y, w, h, r.back_color);
    vs = (h > 3 * t) ? h - 3 * t : 0;
    lo = vs / 2;
    up = vs - lo;
    mid_y = y + lo + t;
    up_y = y + lo + 2 * t;
    right_x = x + w - t;
    bars_ok = (w >= 2 * t);
    bar_w = bars_ok ? w - 2 * t : 0;
    if (bars_ok && (segs & M_TOP) != 0) add_rect(x + t, y + h - t, bar_w, t, fg);
    if (bars_ok && (segs & M_BOT) != 0) add_rect(x + t, y, bar_w, t, fg);
    if (bars_ok && (segs & M_MID) != 0) add_rect(x + t, mid_y, bar_w, t, fg);
    if ((segs & M_UL) != 0) add_rect(x, up_y, t, up, fg);
    if ((segs & M_LL) != 0) add_rect(x, y + t, t, lo, fg);
    if ((segs & M_UR) != 0) add_rect(right_x, up_y, t, up, fg);
    if ((segs & M_LR) != 0) add_rect(right_x, y + t, t, lo, fg);
    if (pending_rects.size() > first) begin
      pending_rects[pending_rects.size() - 1].last_rect = 1'b1;
    end
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_rects(in_item_i);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (!quiet && $urandom_range(0, 99) < in_idle_pct) begin
          gap_left = $urandom_range(0, 8);
          in_valid_i <= 1'b0;
        end else if (req_queue.size() != 0) begin
          next_req = req_queue.pop_front();
          in_item_i <= next_req;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // rectangle monitor and output stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_rects.size() == 0) begin
          report_mismatch("unexpected rectangle, x", out_item_o.rect_x, 0);
        end else begin
          want = pending_rects.pop_front();
          if (out_item_o.rect_x !== want.rect_x)
            report_mismatch("rect_x", out_item_o.rect_x, want.rect_x);
          if (out_item_o.rect_y !== want.rect_y)
            report_mismatch("rect_y", out_item_o.rect_y, want.rect_y);
          if (out_item_o.rect_width !== want.rect_width)
            report_mismatch("rect_width", out_item_o.rect_width, want.rect_width);
          if (out_item_o.rect_height !== want.rect_height)
            report_mismatch("rect_height", out_item_o.rect_height, want.rect_height);
          if (out_item_o.rect_color !== want.rect_color)
            report_mismatch("rect_color", out_item_o.rect_color, want.rect_color);
          if (out_item_o.last_rect !== want.last_rect)
            report_mismatch("last_rect", out_item_o.last_rect, want.last_rect);
        end
      end
      cycle_count++;
      // reroll idle density so some stretches run with no idling at all
      if (cycle_count % 64 == 0) begin
        in_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 35);
        out_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 35);
      end
      if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < out_stall_pct) begin
        stall_left = $urandom_range(0, 8);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic add_req(logic [15:0] x, logic [15:0] y, logic [15:0] w, logic [15:0] h,
                         logic [7:0] d, logic [15:0] fg, logic [15:0] bg);
    req_t r;
    r.origin_x    = x;
    r.origin_y    = y;
    r.box_width   = w;
    r.box_height  = h;
    r.digit_value = d;
    r.fg_color    = fg;
    r.back_color  = bg;
    req_queue.push_back(r);
  endtask

  function automatic logic [15:0] pick_size(int unsigned base);
    int v;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      v = $urandom_range(0, 100);
    end else if (sel < 70) begin
      v = base + $urandom_range(0, 60);
    end else if (sel < 85) begin
      v = int'(base) + int'($urandom_range(0, 6)) - 3;
    end else begin
      v = $urandom_range(0, 65535);
    end
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  task automatic add_random_req();
    logic [7:0] d;
    if ($urandom_range(0, 99) < 85) begin
      d = 8'($urandom_range(0, 9));
    end else begin
      d = 8'($urandom_range(10, 255));
    end
    add_req(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
            pick_size(2 * thick_now), pick_size(3 * thick_now), d,
            16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
  endtask

  task automatic drain();
    int n;
    n = 0;
    @(negedge clk_i);
    while ((req_queue.size() != 0 || in_valid_i || pending_rects.size() != 0)
           && n < DrainLimit) begin
      @(negedge clk_i);
      n++;
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_thickness(logic [ThickW-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    thick_now = value;
  endtask

  initial begin
    logic [ThickW-1:0] thick_plan[8];
    thick_plan[0] = 8'd255;
    thick_plan[1] = 8'd1;
    thick_plan[2] = 8'd0;
    thick_plan[3] = 8'd2;
    thick_plan[4] = 8'($urandom_range(3, 40));
    thick_plan[5] = 8'($urandom_range(41, 253));
    thick_plan[6] = 8'd254;
    thick_plan[7] = ThickReset;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part at the reset thickness
    for (int d = 0; d <= 9; d++) begin
      add_req(16'd100, 16'd50, 16'd40, 16'd70, d[7:0],
              (d % 2) ? 16'hF800 : 16'hFFFF, (d % 2) ? 16'h07E0 : 16'h0000);
    end
    add_req(16'd100, 16'd50, 16'd40, 16'd70, 8'd10, 16'hFFFF, 16'h0000);
    add_req(16'd100, 16'd50, 16'd40, 16'd70, 8'd255, 16'hFFFF, 16'h0000);
    add_req(16'd5, 16'd5, 16'd0, 16'd70, 8'd8, 16'h1234, 16'h4321);
    add_req(16'd5, 16'd5, 16'd40, 16'd0, 8'd8, 16'h1234, 16'h4321);
    add_req(16'd5, 16'd5, 16'd15, 16'd70, 8'd8, 16'h1234, 16'h4321);
    add_req(16'd5, 16'd5, 16'd20, 16'd70, 8'd8, 16'h1234, 16'h4321);
    add_req(16'd5, 16'd5, 16'd40, 16'd29, 8'd0, 16'h1234, 16'h4321);
    add_req(16'd5, 16'd5, 16'd40, 16'd31, 8'd8, 16'h1234, 16'h4321);
    add_req(16'd65530, 16'd65530, 16'd100, 16'd100, 8'd8, 16'hAAAA, 16'h5555);
    add_req(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd8, 16'hFFFF, 16'hFFFF);
    add_req(16'd0, 16'd0, 16'd1, 16'd1, 8'd8, 16'h0000, 16'h0000);
    add_req(16'd0, 16'd0, 16'hFFFF, 16'd3, 8'd8, 16'h5555, 16'hAAAA);
    drain();

    foreach (thick_plan[p]) begin
      write_thickness(thick_plan[p]);
      if (p == 7) quiet = 1'b1;
      add_req(16'd300, 16'd200, 16'(2 * thick_plan[p] + 7), 16'(3 * thick_plan[p] + 9),
              8'd8, 16'hFFFF, 16'h0000);
      repeat (RandPerPhase) add_random_req();
      drain();
    end

    if (pending_rects.size() != 0) begin
      report_mismatch("rectangles never produced", 0, pending_rects.size());
    end
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/ssrg_pkg.sv
sv/ssrg_datapath.sv
sv/ssrg_ctrl.sv
sv/seven_segment_rect_generator_core.sv
sv/ssrg_checker.sv
tb/seven_segment_rect_generator_core_tb.sv
